@@ rtl/command_trace_sequence_checker_macros.svh @@
// Assertion helpers for the command trace sequence checker.
// They sample on aclk and are disabled while aresetn is low.
`ifndef COMMAND_TRACE_SEQUENCE_CHECKER_MACROS_SVH
`define COMMAND_TRACE_SEQUENCE_CHECKER_MACROS_SVH

`ifndef SYNTH

`define CTSC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

`define CTSC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CTSC_ASSERT_SAME(lbl, ante, cons, msg)

`define CTSC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

@@ rtl/ctsc_pkg.sv @@
package ctsc_pkg;

    typedef enum logic [1:0] {
        OP_RECORD   = 2'd0,
        OP_FINALIZE = 2'd1,
        OP_ABANDON  = 2'd2,
        OP_UNUSED   = 2'd3
    } opcode_t;

    typedef enum logic [3:0] {
        ST_OK          = 4'd0,
        ST_CLOSED      = 4'd1,
        ST_SCHEMA      = 4'd2,
        ST_EVENT_LIMIT = 4'd3,
        ST_TICK_BACK   = 4'd4,
        ST_OVERLAP     = 4'd5,
        ST_ACK_MISMATCH = 4'd6,
        ST_ACK_UNRELATED = 4'd7,
        ST_NO_COMMAND  = 4'd8,
        ST_BYTE_LIMIT  = 4'd9,
        ST_UNCLEAN     = 4'd10,
        ST_DROPPED     = 4'd11
    } status_t;

    typedef enum logic [1:0] {
        CFG_EVENT_LIMIT     = 2'd0,
        CFG_PAYLOAD_ROOM    = 2'd1,
        CFG_EXPECTED_SCHEMA = 2'd2,
        CFG_NONE            = 2'd3
    } cfg_index_t;

    // event type codes
    localparam logic [3:0] EV_PACKET   = 4'd1;
    localparam logic [3:0] EV_RESET    = 4'd2;
    localparam logic [3:0] EV_LOAD     = 4'd3;
    localparam logic [3:0] EV_ABORT    = 4'd4;
    localparam logic [3:0] EV_ACK      = 4'd5;
    localparam logic [3:0] EV_COMPLETE = 4'd6;

    localparam int IN_DATA_W  = 384;
    localparam int IN_USER_W  = 6;
    localparam int OUT_DATA_W = 280;

    localparam logic [31:0] EVENT_LIMIT_RST = 32'hFFFF_FFFF;
    localparam logic [47:0] PAYLOAD_ROOM_RST = 48'hFFFF_FFFF_FFFF;
    localparam logic [31:0] SCHEMA_RST = 32'd1;

endpackage

@@ rtl/command_trace_sequence_checker.sv @@
// Command trace sequence checker.
// Each word passes the input register, then the result register, before its
// result word is valid.
// Throughput: one word per cycle while m_tready does not stall the result stage.
// Reset: synchronous, active low; clears all sequencing state and counters and
// returns the configuration registers to their defaults at once.
`include "command_trace_sequence_checker_macros.svh"

module command_trace_sequence_checker #(
    parameter int TYPE_SLOTS = 15
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // fields low to high: schema_version, event_tick, command_generation,
    // sector_count, sector_size, bytes_moved, record_length, drop_count
    input  logic [ctsc_pkg::IN_DATA_W-1:0]    s_tdata,
    // fields low to high: opcode, event_type
    input  logic [ctsc_pkg::IN_USER_W-1:0]    s_tuser,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // fields low to high: status, event_ordinal, accepted_events, bytes_used,
    // commands_done, first_tick, last_tick, zero pad
    output logic [ctsc_pkg::OUT_DATA_W-1:0]   m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [1:0]                        cfg_index,
    input  logic [47:0]                       cfg_data
);

    // config
    logic [31:0] event_limit_reg;
    logic [47:0] payload_room_reg;
    logic [31:0] expected_schema_reg;

    // input stage
    logic                            in_valid_reg;
    logic [ctsc_pkg::IN_DATA_W-1:0]  in_data_reg;
    logic [ctsc_pkg::IN_USER_W-1:0]  in_user_reg;

    // result stage
    logic                 out_valid_reg;
    ctsc_pkg::status_t    status_reg;
    logic [31:0]          ordinal_reg;

    // sequencing state
    logic        done_flag_reg, dropped_flag_reg, seen_any_reg;
    logic        cmd_open_reg, ack_pending_reg, tainted_reg;
    logic [63:0] open_gen_reg, completed_gen_reg, expected_total_reg;
    logic [31:0] event_total_reg, complete_total_reg;
    logic [47:0] byte_total_reg;
    logic [63:0] start_time_reg, end_time_reg;
    logic [31:0] per_type_counts_reg [TYPE_SLOTS];

    // next values
    logic        done_flag_next, dropped_flag_next;
    logic        cmd_open_next, ack_pending_next, tainted_next;
    logic [63:0] open_gen_next, completed_gen_next, expected_total_next;
    logic [31:0] complete_total_next;
    ctsc_pkg::status_t status_next;
    logic [31:0] ordinal_next;
    logic        commit;

    // field views
    ctsc_pkg::opcode_t op;
    logic [3:0]  ev_type;
    logic [31:0] schema, sec_count, sec_size, rec_len;
    logic [63:0] tick, gen, bytes_moved, drop_count;
    logic [63:0] product;
    logic [48:0] room_left;
    logic        byte_fail;
    logic        seq_err;
    ctsc_pkg::status_t seq_code;
    logic        advance;

    assign op          = ctsc_pkg::opcode_t'(in_user_reg[1:0]);
    assign ev_type     = in_user_reg[5:2];
    assign schema      = in_data_reg[31:0];
    assign tick        = in_data_reg[95:32];
    assign gen         = in_data_reg[159:96];
    assign sec_count   = in_data_reg[191:160];
    assign sec_size    = in_data_reg[223:192];
    assign bytes_moved = in_data_reg[287:224];
    assign rec_len     = in_data_reg[319:288];
    assign drop_count  = in_data_reg[383:320];

    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    assign product   = 64'(sec_count) * 64'(sec_size);
    assign room_left = {1'b0, payload_room_reg} - {1'b0, byte_total_reg};
    assign byte_fail = room_left[48] || ({16'd0, rec_len} > room_left[47:0]);

    // sequencing rules per event type
    always_comb begin
        seq_err             = 1'b0;
        seq_code            = ctsc_pkg::ST_OK;
        cmd_open_next       = cmd_open_reg;
        ack_pending_next    = ack_pending_reg;
        tainted_next        = tainted_reg;
        open_gen_next       = open_gen_reg;
        completed_gen_next  = completed_gen_reg;
        expected_total_next = expected_total_reg;
        complete_total_next = complete_total_reg;
        unique case (ev_type)
            ctsc_pkg::EV_PACKET: begin
                if (cmd_open_reg || ack_pending_reg || gen == 64'd0) begin
                    seq_err  = 1'b1;
                    seq_code = ctsc_pkg::ST_OVERLAP;
                end
                cmd_open_next       = 1'b1;
                open_gen_next       = gen;
                expected_total_next = product;
            end
            ctsc_pkg::EV_RESET, ctsc_pkg::EV_LOAD: begin
                if (cmd_open_reg || ack_pending_reg) tainted_next = 1'b1;
                cmd_open_next    = 1'b0;
                ack_pending_next = 1'b0;
            end
            ctsc_pkg::EV_ABORT: begin
                if (cmd_open_reg && gen == open_gen_reg) tainted_next = 1'b1;
                cmd_open_next = 1'b0;
            end
            ctsc_pkg::EV_ACK: begin
                if (cmd_open_reg) begin
                    if (gen != open_gen_reg) begin
                        seq_err  = 1'b1;
                        seq_code = ctsc_pkg::ST_ACK_MISMATCH;
                    end
                end else if (!ack_pending_reg || gen != completed_gen_reg) begin
                    seq_err  = 1'b1;
                    seq_code = ctsc_pkg::ST_ACK_UNRELATED;
                end else begin
                    ack_pending_next = 1'b0;
                end
            end
            default: begin
                // type zero and unnamed types fall here with complete
                if (!cmd_open_reg || gen != open_gen_reg) begin
                    seq_err  = 1'b1;
                    seq_code = ctsc_pkg::ST_NO_COMMAND;
                end else if (ev_type == ctsc_pkg::EV_COMPLETE) begin
                    if (bytes_moved != expected_total_reg) tainted_next = 1'b1;
                    cmd_open_next       = 1'b0;
                    complete_total_next = complete_total_reg + 32'd1;
                    ack_pending_next    = 1'b1;
                    completed_gen_next  = gen;
                end
            end
        endcase
    end

    // opcode handling and check order
    always_comb begin
        status_next       = ctsc_pkg::ST_OK;
        ordinal_next      = 32'd0;
        commit            = 1'b0;
        done_flag_next    = done_flag_reg;
        dropped_flag_next = dropped_flag_reg;
        unique case (op)
            ctsc_pkg::OP_RECORD: begin
                priority if (done_flag_reg) begin
                    status_next = ctsc_pkg::ST_CLOSED;
                end else if (schema != expected_schema_reg) begin
                    status_next = ctsc_pkg::ST_SCHEMA;
                end else if (event_total_reg >= event_limit_reg) begin
                    status_next = ctsc_pkg::ST_EVENT_LIMIT;
                end else if (seen_any_reg && tick < end_time_reg) begin
                    status_next = ctsc_pkg::ST_TICK_BACK;
                end else if (seq_err) begin
                    status_next = seq_code;
                end else if (byte_fail) begin
                    status_next = ctsc_pkg::ST_BYTE_LIMIT;
                end else begin
                    commit       = 1'b1;
                    ordinal_next = event_total_reg;
                end
            end
            ctsc_pkg::OP_FINALIZE: begin
                priority if (done_flag_reg) begin
                    status_next = ctsc_pkg::ST_CLOSED;
                end else if (!seen_any_reg || cmd_open_reg || ack_pending_reg ||
                             tainted_reg || complete_total_reg == 32'd0) begin
                    status_next = ctsc_pkg::ST_UNCLEAN;
                end else if (drop_count != 64'd0) begin
                    status_next       = ctsc_pkg::ST_DROPPED;
                    dropped_flag_next = 1'b1;
                end else begin
                    done_flag_next = 1'b1;
                end
            end
            ctsc_pkg::OP_ABANDON: begin
                done_flag_next = 1'b1;
            end
            ctsc_pkg::OP_UNUSED: begin
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            event_limit_reg     <= ctsc_pkg::EVENT_LIMIT_RST;
            payload_room_reg    <= ctsc_pkg::PAYLOAD_ROOM_RST;
            expected_schema_reg <= ctsc_pkg::SCHEMA_RST;
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            done_flag_reg       <= 1'b0;
            dropped_flag_reg    <= 1'b0;
            seen_any_reg        <= 1'b0;
            cmd_open_reg        <= 1'b0;
            ack_pending_reg     <= 1'b0;
            tainted_reg         <= 1'b0;
            open_gen_reg        <= 64'd0;
            completed_gen_reg   <= 64'd0;
            expected_total_reg  <= 64'd0;
            event_total_reg     <= 32'd0;
            complete_total_reg  <= 32'd0;
            byte_total_reg      <= 48'd0;
            start_time_reg      <= 64'd0;
            end_time_reg        <= 64'd0;
            for (int i = 0; i < TYPE_SLOTS; i++) begin
                per_type_counts_reg[i] <= 32'd0;
            end
        end else begin
            if (cfg_valid) begin
                unique case (ctsc_pkg::cfg_index_t'(cfg_index))
                    ctsc_pkg::CFG_EVENT_LIMIT:     event_limit_reg <= cfg_data[31:0];
                    ctsc_pkg::CFG_PAYLOAD_ROOM:    payload_room_reg <= cfg_data;
                    ctsc_pkg::CFG_EXPECTED_SCHEMA: expected_schema_reg <= cfg_data[31:0];
                    ctsc_pkg::CFG_NONE: begin
                    end
                    default: begin
                    end
                endcase
            end

            if (s_tvalid && s_tready) begin
                in_valid_reg <= 1'b1;
                in_data_reg  <= s_tdata;
                in_user_reg  <= s_tuser;
            end else if (advance) begin
                in_valid_reg <= 1'b0;
            end

            if (advance) begin
                out_valid_reg    <= 1'b1;
                status_reg       <= status_next;
                ordinal_reg      <= ordinal_next;
                done_flag_reg    <= done_flag_next;
                dropped_flag_reg <= dropped_flag_next;
                if (commit) begin
                    cmd_open_reg       <= cmd_open_next;
                    ack_pending_reg    <= ack_pending_next;
                    tainted_reg        <= tainted_next;
                    open_gen_reg       <= open_gen_next;
                    completed_gen_reg  <= completed_gen_next;
                    expected_total_reg <= expected_total_next;
                    complete_total_reg <= complete_total_next;
                    if (!seen_any_reg) start_time_reg <= tick;
                    end_time_reg       <= tick;
                    byte_total_reg     <= byte_total_reg + 48'(rec_len);
                    event_total_reg    <= event_total_reg + 32'd1;
                    seen_any_reg       <= 1'b1;
                    for (int i = 0; i < TYPE_SLOTS; i++) begin
                        if ({28'd0, ev_type} == 32'(i + 1)) begin
                            per_type_counts_reg[i] <= per_type_counts_reg[i] + 32'd1;
                        end
                    end
                end
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // counters are read straight from state: it only moves when a new result is loaded
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'd0, end_time_reg, start_time_reg, complete_total_reg,
                       byte_total_reg, event_total_reg, ordinal_reg, status_reg};

    `CTSC_ASSERT_NEXT(a_ok_counts, advance && commit,
        event_total_reg == $past(event_total_reg) + 32'd1, "accepted event not counted")
    `CTSC_ASSERT_NEXT(a_reject_holds, advance && op == ctsc_pkg::OP_RECORD && !commit,
        $stable(byte_total_reg) && $stable(event_total_reg) && $stable(end_time_reg),
        "rejected event changed state")
    `CTSC_ASSERT_NEXT(a_done_sticks, done_flag_reg, done_flag_reg, "closed checker reopened")
    `CTSC_ASSERT_SAME(a_open_no_ack, cmd_open_reg, !ack_pending_reg,
        "open command with pending ack")
    `CTSC_ASSERT_SAME(a_ready_when_free, !out_valid_reg, s_tready,
        "input stalled with empty result stage")

endmodule
